// ===== src/barometric_sensor_compensation_unit_assert.svh =====
// Assertion macros used by the barometric compensation sequencer.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BSCU_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BSCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BSCU_ASSERT(lbl, clk, rst_n, ante, cons)
`define BSCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/bscu_pkg.sv =====
// Shared types, constants and helper functions of the barometric compensation unit.
package bscu_pkg;
  localparam int unsigned NumCalib = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RawW = 20;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = 1;
  localparam int unsigned StepW = 4;
  localparam int unsigned DivCntW = 7;
  localparam logic [StepW-1:0] LastTempStep = 4'd9;
  localparam logic [StepW-1:0] FirstPostStep = 4'd10;
  localparam logic [StepW-1:0] LastStep = 4'd12;

  typedef logic [NumCalib-1:0][31:0] calib_t;

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } raw_item_t;

  function automatic logic [63:0] sx16(input logic [15:0] x);
    sx16 = {{48{x[15]}}, x};
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] x);
    sx32 = {{32{x[31]}}, x};
  endfunction
endpackage

// ===== src/bscu_front.sv =====
// Input side: accepts raw reading requests into a two-entry queue.
module bscu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bscu_pkg::raw_item_t in_item_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output bscu_pkg::raw_item_t q_item_o
);
  bscu_pkg::raw_item_t mem_q [bscu_pkg::QueueDepth];
  logic [bscu_pkg::QueuePtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [bscu_pkg::QueuePtrW:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'(bscu_pkg::QueueDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_pop_i && q_valid_o;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end
endmodule

// ===== src/bscu_mul.sv =====
// Wrapping 64 by 64 multiplier built on one 32 by 32 multiplier, summing the partial products in turn.
module bscu_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o
);
  logic [63:0] a_q, b_q, acc_q, acc_d, prod;
  logic [1:0]  ph_q, ph_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [31:0] ma, mb;

  assign ma = (ph_q == 2'd2) ? a_q[63:32] : a_q[31:0];
  assign mb = (ph_q == 2'd1) ? b_q[63:32] : b_q[31:0];
  assign prod = 64'(ma) * 64'(mb);

  always_comb begin
    acc_d  = acc_q;
    ph_d   = ph_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      case (ph_q)
        2'd0: acc_d = prod;
        default: acc_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
      endcase
      ph_d = ph_q + 2'd1;
      if (ph_q == 2'd2) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        ph_d   = 2'd0;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      ph_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i && !busy_q) begin
      a_q <= a_i;
      b_q <= b_i;
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;
endmodule

// ===== src/bscu_div.sv =====
// Truncating signed 64-bit divider, one quotient bit per cycle.
module bscu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d, shifted;
  logic [64:0] trial;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [bscu_pkg::DivCntW-1:0] cnt_q, cnt_d;

  assign shifted = {rem_q[62:0], quo_q[63]};
  assign trial   = {1'b0, shifted} - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i[63] ? 64'd0 - num_i : num_i;
      dvs_d  = den_i[63] ? 64'd0 - den_i : den_i;
      neg_d  = num_i[63] ^ den_i[63];
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? 64'd0 - quo_q : quo_q;
endmodule

// ===== src/bscu_back.sv =====
// Compensation sequencer: runs the temperature and pressure formulas and holds the result.
`include "barometric_sensor_compensation_unit_assert.svh"
module bscu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bscu_pkg::calib_t    calib_i,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  bscu_pkg::raw_item_t q_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         out_temp_o,
  output logic [31:0]         out_pres_o,
  output logic                out_inv_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_MWAIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DWAIT = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [bscu_pkg::StepW-1:0] step_q, step_d;
  logic [19:0] rp_q, rp_d, rt_q, rt_d;
  logic [31:0] ta_q, ta_d, ea_q, ea_d, tf_q, tf_d, temp_q, temp_d;
  logic [63:0] sq_q, sq_d, v2_q, v2_d, w_q, w_d, dv_q, dv_d, n_q, n_d;
  logic [63:0] qt_q, qt_d, x_q, x_d;
  logic        inv_q, inv_d;
  logic        ov_q, ov_d;
  logic [31:0] otemp_q, otemp_d, opres_q, opres_d;
  logic        oinv_q, oinv_d;

  logic [31:0] t1, x1, dd, m5;
  logic [63:0] v1, p0, ps, op_a, op_b, mres, dres, pfin;
  logic        mul_start, mul_done, div_start, div_done, out_free;

  assign t1 = {16'd0, calib_i[0][15:0]};
  assign x1 = {15'd0, rt_q[19:3]} - {t1[30:0], 1'b0};
  assign dd = {16'd0, rt_q[19:4]} - t1;
  assign v1 = bscu_pkg::sx32(tf_q) - 64'd128000;
  assign p0 = 64'd1048576 - {44'd0, rp_q};
  assign ps = 64'($signed(qt_q) >>> 13);
  assign m5 = {tf_q[29:0], 2'b00} + tf_q + 32'd128;
  assign pfin = 64'($signed(x_q) >>> 8) +
                {{44{calib_i[4][31]}}, calib_i[4][31:16], 4'd0};
  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    case (step_q)
      4'd0: begin op_a = bscu_pkg::sx32(x1); op_b = bscu_pkg::sx16(calib_i[0][31:16]); end
      4'd1: begin op_a = bscu_pkg::sx32(dd); op_b = bscu_pkg::sx32(dd); end
      4'd2: begin op_a = bscu_pkg::sx32(ea_q); op_b = bscu_pkg::sx16(calib_i[1][15:0]); end
      4'd3: begin op_a = v1; op_b = v1; end
      4'd4: begin op_a = sq_q; op_b = bscu_pkg::sx16(calib_i[4][15:0]); end
      4'd5: begin op_a = v1; op_b = bscu_pkg::sx16(calib_i[3][31:16]); end
      4'd6: begin op_a = sq_q; op_b = bscu_pkg::sx16(calib_i[2][31:16]); end
      4'd7: begin op_a = v1; op_b = bscu_pkg::sx16(calib_i[2][15:0]); end
      4'd8: begin op_a = (64'd1 << 47) + w_q; op_b = {48'd0, calib_i[1][31:16]}; end
      4'd9: begin op_a = {p0[32:0], 31'd0} - v2_q; op_b = 64'd3125; end
      4'd10: begin op_a = bscu_pkg::sx16(calib_i[5][31:16]); op_b = ps; end
      4'd11: begin op_a = x_q; op_b = ps; end
      4'd12: begin op_a = bscu_pkg::sx16(calib_i[5][15:0]); op_b = qt_q; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    rp_d = rp_q; rt_d = rt_q;
    ta_d = ta_q; ea_d = ea_q; tf_d = tf_q; temp_d = temp_q;
    sq_d = sq_q; v2_d = v2_q; w_d = w_q; dv_d = dv_q; n_d = n_q;
    qt_d = qt_q; x_d = x_q; inv_d = inv_q;
    ov_d = ov_q; otemp_d = otemp_q; opres_d = opres_q; oinv_d = oinv_q;
    q_pop_o   = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          rp_d    = q_item_i.raw_pressure;
          rt_d    = q_item_i.raw_temperature;
          step_d  = '0;
          inv_d   = 1'b0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        mul_start = 1'b1;
        state_d   = S_MWAIT;
      end
      S_MWAIT: begin
        if (mul_done) begin
          step_d  = step_q + 1'b1;
          state_d = S_MUL;
          case (step_q)
            4'd0: ta_d = 32'($signed(mres[31:0]) >>> 11);
            4'd1: ea_d = 32'($signed(mres[31:0]) >>> 12);
            4'd2: tf_d = ta_q + 32'($signed(mres[31:0]) >>> 14);
            4'd3: begin
              sq_d   = mres;
              temp_d = 32'($signed(m5) >>> 8);
            end
            4'd4: v2_d = mres;
            4'd5: v2_d = v2_q + {mres[46:0], 17'd0} +
                         {{13{calib_i[3][15]}}, calib_i[3][15:0], 35'd0};
            4'd6: w_d = 64'($signed(mres) >>> 8);
            4'd7: w_d = w_q + {mres[51:0], 12'd0};
            4'd8: dv_d = 64'($signed(mres) >>> 33);
            4'd9: begin
              n_d = mres;
              if (dv_q == 64'd0) begin
                inv_d   = 1'b1;
                state_d = S_OUT;
              end else begin
                state_d = S_DIV;
              end
            end
            4'd10: x_d = mres;
            4'd11: x_d = 64'($signed(mres) >>> 25);
            4'd12: begin
              x_d     = qt_q + x_q + 64'($signed(mres) >>> 19);
              state_d = S_OUT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          qt_d    = dres;
          step_d  = bscu_pkg::FirstPostStep;
          state_d = S_MUL;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          otemp_d = temp_q;
          opres_d = inv_q ? 32'd0 : pfin[31:0];
          oinv_d  = inv_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q <= rp_d; rt_q <= rt_d;
    ta_q <= ta_d; ea_q <= ea_d; tf_q <= tf_d; temp_q <= temp_d;
    sq_q <= sq_d; v2_q <= v2_d; w_q <= w_d; dv_q <= dv_d; n_q <= n_d;
    qt_q <= qt_d; x_q <= x_d; inv_q <= inv_d;
    otemp_q <= otemp_d; opres_q <= opres_d; oinv_q <= oinv_d;
  end

  bscu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .res_o   (mres)
  );

  bscu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (n_q),
    .den_i   (dv_q),
    .done_o  (div_done),
    .quo_o   (dres)
  );

  assign out_valid_o = ov_q;
  assign out_temp_o  = otemp_q;
  assign out_pres_o  = opres_q;
  assign out_inv_o   = oinv_q;

  `BSCU_ASSERT(a_mul_done_wait, clk_i, rst_ni, mul_done, state_q == S_MWAIT)
  `BSCU_ASSERT(a_div_done_wait, clk_i, rst_ni, div_done, state_q == S_DWAIT)
  `BSCU_ASSERT_NEXT(a_out_load, clk_i, rst_ni, state_q == S_OUT && out_free, ov_q)
  `BSCU_ASSERT(a_inv_zero, clk_i, rst_ni, ov_q && oinv_q, opres_q == 32'd0)
endmodule

// ===== src/barometric_sensor_compensation_unit.sv =====
// Top level of the barometric compensation unit: calibration registers, queue and sequencer.
// Each request carries raw pressure and temperature readings and yields one result with
// the temperature in 0.01 degC, the pressure in Pa as Q24.8 and a flag set when the
// pressure divisor is zero. An item is taken from the queue, then runs thirteen 64-bit
// products on one shared 32 by 32 multiplier and the 64-step bit-serial divider, and its
// result is then loaded into the output register. An item with a zero divisor skips the
// divider and the last three products. Requests are queued two deep and the result waits
// in an output register, so input and output stall independently. The user must write
// calibration only while the unit is idle; the unit itself does not enforce this.
module barometric_sensor_compensation_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bscu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // raw_pressure [19:0], raw_temperature [39:20]
  input  logic [39:0]                  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // temperature_centi [31:0], pressure_q24_8 [63:32]
  output logic [63:0]                  m_axis_tdata,
  // pressure_invalid [0]
  output logic                         m_axis_tuser
);
  bscu_pkg::calib_t    calib_q;
  bscu_pkg::raw_item_t in_item, q_item;
  logic                q_valid, q_pop;
  logic [31:0]         temp, pres;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i < 3'(bscu_pkg::NumCalib))) begin
      calib_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign in_item.raw_pressure    = s_axis_tdata[19:0];
  assign in_item.raw_temperature = s_axis_tdata[39:20];

  bscu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  bscu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .calib_i     (calib_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_temp_o  (temp),
    .out_pres_o  (pres),
    .out_inv_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {pres, temp};
endmodule

// ===== test/barometric_sensor_compensation_unit_test.sv =====
// Self-checking testbench of the barometric compensation unit with random handshake gaps.
`timescale 1ns / 1ps

module barometric_sensor_compensation_unit_test;

  typedef enum logic [2:0] {
    RegT1T2 = 3'd0,
    RegT3P1 = 3'd1,
    RegP2P3 = 3'd2,
    RegP4P5 = 3'd3,
    RegP6P7 = 3'd4,
    RegP8P9 = 3'd5,
    RegNone6 = 3'd6,
    RegNone7 = 3'd7
  } calib_reg_e;

  typedef struct {
    logic [31:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic        pressure_invalid;
  } reading_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [bscu_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic m_axis_tuser;

  logic [31:0] calib_regs [bscu_pkg::NumCalib];
  reading_t expected_readings [$];
  int error_count;
  int result_count;
  int request_count;
  int invalid_count;
  int hold_off_cycles;
  bit sender_gaps;

  barometric_sensor_compensation_unit i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [63:0] asr64(input logic [63:0] x, input int s);
    asr64 = $signed(x) >>> s;
  endfunction

  function automatic logic [63:0] half_signed(input logic [15:0] h);
    half_signed = {{48{h[15]}}, h};
  endfunction

  // Integer compensation with 32-bit wrap for temperature and 64-bit wrap for pressure.
  function automatic reading_t compensate(input logic [19:0] adc_p, input logic [19:0] adc_t);
    reading_t r;
    logic [31:0] t1, t2, t3, a, d, tfine;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, p, num, ua, ub, q, ps, q1, q2;
    t1 = {16'd0, calib_regs[RegT1T2][15:0]};
    t2 = {{16{calib_regs[RegT1T2][31]}}, calib_regs[RegT1T2][31:16]};
    t3 = {{16{calib_regs[RegT3P1][15]}}, calib_regs[RegT3P1][15:0]};
    p1 = {48'd0, calib_regs[RegT3P1][31:16]};
    p2 = half_signed(calib_regs[RegP2P3][15:0]);
    p3 = half_signed(calib_regs[RegP2P3][31:16]);
    p4 = half_signed(calib_regs[RegP4P5][15:0]);
    p5 = half_signed(calib_regs[RegP4P5][31:16]);
    p6 = half_signed(calib_regs[RegP6P7][15:0]);
    p7 = half_signed(calib_regs[RegP6P7][31:16]);
    p8 = half_signed(calib_regs[RegP8P9][15:0]);
    p9 = half_signed(calib_regs[RegP8P9][31:16]);
    a = 32'($signed(32'((({12'd0, adc_t} >> 3) - (t1 << 1)) * t2)) >>> 11);
    d = {12'd0, adc_t} >> 4;
    d = d - t1;
    d = 32'($signed(32'(d * d)) >>> 12);
    d = 32'($signed(32'(d * t3)) >>> 14);
    tfine = a + d;
    r.temperature_centi = 32'($signed(32'(tfine * 32'd5 + 32'd128)) >>> 8);
    v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
    r.pressure_q24_8 = 32'd0;
    r.pressure_invalid = (v1 == 64'd0);
    if (v1 != 64'd0) begin
      p = 64'd1048576 - {44'd0, adc_p};
      num = ((p << 31) - v2) * 64'd3125;
      ua = num[63] ? -num : num;
      ub = v1[63] ? -v1 : v1;
      q = ua / ub;
      p = (num[63] != v1[63]) ? -q : q;
      ps = asr64(p, 13);
      q1 = asr64(p9 * ps * ps, 25);
      q2 = asr64(p8 * p, 19);
      p = asr64(p + q1 + q2, 8) + (p7 << 4);
      r.pressure_q24_8 = p[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("Mismatch at result %0d: %s got %h expected %h", result_count, what, got, want);
    error_count++;
  endtask

  task automatic write_calib(input calib_reg_e index, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index < bscu_pkg::NumCalib) calib_regs[index] = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Valid stays high after acceptance so that requests can follow back to back.
  task automatic send_request(input logic [19:0] adc_p, input logic [19:0] adc_t);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 9) : 0;
    if (($urandom_range(0, 3) == 0) || !sender_gaps) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {adc_t, adc_p};
    expected_readings.push_back(compensate(adc_p, adc_t));
    request_count++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  // Ready is drawn anew after each result, with occasional long hold-offs.
  initial begin
    int wait_cycles;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    reading_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
        end else begin
          want = expected_readings.pop_front();
          if (m_axis_tdata[31:0] !== want.temperature_centi)
            report_mismatch("temperature", m_axis_tdata[31:0], want.temperature_centi);
          if (m_axis_tdata[63:32] !== want.pressure_q24_8)
            report_mismatch("pressure", m_axis_tdata[63:32], want.pressure_q24_8);
          if (m_axis_tuser !== want.pressure_invalid)
            report_mismatch("invalid flag", {31'd0, m_axis_tuser}, {31'd0, want.pressure_invalid});
          if (want.pressure_invalid) invalid_count++;
        end
        result_count++;
      end
    end
  end

  // Typical datasheet calibration; the random test varies one register around it.
  task automatic load_typical_calib();
    write_calib(RegT1T2, {16'd26435, 16'd27504});
    write_calib(RegT3P1, {16'd36477, 16'hFC18});
    write_calib(RegP2P3, {16'd3024, -16'sd10685});
    write_calib(RegP4P5, {-16'sd19, 16'd2855});
    write_calib(RegP6P7, {16'd15500, -16'sd7});
    write_calib(RegP8P9, {16'd6000, -16'sd14600});
  endtask

  task automatic test_directed();
    load_typical_calib();
    write_calib(RegNone6, 32'hDEAD_BEEF);
    write_calib(RegNone7, 32'h1234_5678);
    send_request(20'd415148, 20'd519888);
    send_request(20'h00000, 20'h00000);
    send_request(20'hFFFFF, 20'hFFFFF);
    send_request(20'h00000, 20'hFFFFF);
    send_request(20'hFFFFF, 20'h00000);
    send_request(20'h55555, 20'hAAAAA);
    send_request(20'hAAAAA, 20'h55555);
    wait_drained();
    // Zero P1 gives a zero divisor.
    write_calib(RegT3P1, {16'd0, 16'hFC18});
    send_request(20'd415148, 20'd519888);
    send_request(20'hFFFFF, 20'h0);
    wait_drained();
    // Extreme coefficients in both signs.
    for (int k = 0; k < bscu_pkg::NumCalib; k++) write_calib(calib_reg_e'(k), 32'hFFFF_FFFF);
    send_request(20'hFFFFF, 20'hFFFFF);
    send_request(20'h0, 20'h0);
    wait_drained();
    for (int k = 0; k < bscu_pkg::NumCalib; k++) write_calib(calib_reg_e'(k), 32'h8000_7FFF);
    send_request(20'hFFFFF, 20'h12345);
    send_request(20'h0, 20'hFFFFF);
    wait_drained();
    for (int k = 0; k < bscu_pkg::NumCalib; k++) write_calib(calib_reg_e'(k), 32'h7FFF_8000);
    send_request(20'h80000, 20'h80000);
    send_request(20'h1, 20'h1);
    wait_drained();
    for (int k = 0; k < bscu_pkg::NumCalib; k++) write_calib(calib_reg_e'(k), 32'h0);
    send_request(20'h12345, 20'h54321);
    wait_drained();
  endtask

  task automatic test_random_readings(input int count, input bit wild_calib);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        wait_drained();
        if (wild_calib) begin
          for (int k = 0; k < bscu_pkg::NumCalib; k++)
            write_calib(calib_reg_e'(k), $urandom());
          if ($urandom_range(0, 3) == 0) write_calib(RegT3P1, {16'd0, 16'($urandom())});
        end else begin
          load_typical_calib();
          write_calib(calib_reg_e'($urandom_range(0, 5)), $urandom());
        end
      end
      if ($urandom_range(0, 1) == 0)
        send_request(20'($urandom_range(250000, 600000)), 20'($urandom_range(400000, 600000)));
      else
        send_request(20'($urandom()), 20'($urandom()));
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    load_typical_calib();
    hold_off_cycles = 2000;
    sender_gaps = 1'b0;
    for (int n = 0; n < 8; n++) send_request(20'($urandom()), 20'($urandom()));
    sender_gaps = 1'b1;
    wait_drained();
    for (int n = 0; n < 5; n++) send_request(20'($urandom()), 20'($urandom()));
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    error_count = 0;
    result_count = 0;
    request_count = 0;
    invalid_count = 0;
    hold_off_cycles = 0;
    sender_gaps = 1'b1;
    for (int k = 0; k < bscu_pkg::NumCalib; k++) calib_regs[k] = 32'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_readings(450, 1'b0);
    test_random_readings(450, 1'b1);
    if (expected_readings.size() != 0) begin
      $display("%0d results never arrived", expected_readings.size());
      error_count++;
    end
    $display("Sent %0d readings, checked %0d results, %0d with a zero divisor.",
             request_count, result_count, invalid_count);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
